FILE: rtl/als_pkg.sv
// Shared types and constants for the address lease server.
// Message, reply, pool entry, configuration and controller/datapath interface types.
// No dependencies.
package als_pkg;

  localparam int POOL_DEPTH_DEF = 1024;
  localparam int POOL_W = 11;
  localparam int TIME_W = 30;
  localparam int END_W = 31;
  localparam int ID_W = 16;

  // Message kinds
  localparam logic [1:0] DIS = 2'd0;
  localparam logic [1:0] REQ = 2'd1;

  // Reply kinds
  localparam logic [1:0] OFR = 2'd0;
  localparam logic [1:0] ACK = 2'd1;
  localparam logic [1:0] NAK = 2'd2;

  // Entry status codes
  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_OFFERED = 2'd1;
  localparam logic [1:0] ST_ASSIGNED = 2'd2;
  localparam logic [1:0] ST_EXPIRED = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_POOL_SIZE = 3'd0;
  localparam logic [2:0] CFG_DEFAULT_LEASE = 3'd1;
  localparam logic [2:0] CFG_MAX_LEASE = 3'd2;
  localparam logic [2:0] CFG_MIN_LEASE = 3'd3;
  localparam logic [2:0] CFG_SERVER_ID = 3'd4;

  typedef struct packed {
    logic [TIME_W-1:0] arrival_time;
    logic [ID_W-1:0]   sender_id;
    logic              to_broadcast;
    logic [ID_W-1:0]   receiver_id;
    logic [1:0]        kind;
    logic [ID_W-1:0]   asked_address;
    logic [TIME_W-1:0] asked_end;
  } msg_t;

  typedef struct packed {
    logic [1:0]       reply_type;
    logic [ID_W-1:0]  client_id;
    logic [ID_W-1:0]  address;
    logic [END_W-1:0] lease_end;
  } reply_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  owner;
    logic [END_W-1:0] lease_end;
  } entry_t;

  typedef struct packed {
    logic [POOL_W-1:0] pool_size;
    logic [TIME_W-1:0] default_lease;
    logic [TIME_W-1:0] max_lease;
    logic [TIME_W-1:0] min_lease;
    logic [ID_W-1:0]   server_id;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/als_ctrl.sv
// Controller state machine for the address lease server.
// Sequences the clearing pass, message load, pool scan and commit.
// Depends on als_pkg.
module als_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output als_pkg::cmd_t cmd,
  input  als_pkg::sts_t sts
);
  import als_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t state, state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign req_stall = (state != S_IDLE);

endmodule

FILE: rtl/als_dp.sv
// Datapath for the address lease server: pool memory, scan pipeline,
// lease arithmetic and reply register.
// Depends on als_pkg.
module als_dp #(
  parameter int POOL_DEPTH = als_pkg::POOL_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  als_pkg::cmd_t   cmd,
  output als_pkg::sts_t   sts,
  input  als_pkg::cfg_t   cfg,
  input  als_pkg::msg_t   msg,
  input  logic            rsp_stall,
  output logic            rsp_valid,
  output als_pkg::reply_t rsp_data
);
  import als_pkg::*;

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int NW = (CW > POOL_W) ? CW : POOL_W;

  entry_t mem [POOL_DEPTH];
  entry_t rdata;
  logic   re;
  logic [AW-1:0] raddr;
  logic   we;
  logic [AW-1:0] waddr;
  entry_t wdata;

  msg_t item;
  logic is_dis, is_req, is_rel, addr_ok;
  logic [CW-1:0] n_cfg, n_q;
  logic [AW-1:0] clr_idx;
  logic [CW-1:0] rd_idx;
  logic rd_vld;
  logic [AW-1:0] wb_addr;
  entry_t ent_exp, ent_wb;

  logic own_hit, free_hit, exp_hit;
  logic [AW-1:0] own_idx, free_idx, exp_idx;
  logic [1:0] tgt_st;
  logic [ID_W-1:0] tgt_owner;

  logic [END_W-1:0] lease_dflt, lease_lo, lease_hi, lease_val, lease_mid;
  logic offer, grant, has_reply;
  logic [AW-1:0] sel_idx;
  logic [ID_W-1:0] req_addr_m1;

  // Pool memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // Clamp the configured pool size to the depth
  always_comb begin
    if (NW'(cfg.pool_size) > NW'(POOL_DEPTH)) n_cfg = CW'(POOL_DEPTH);
    else n_cfg = CW'(cfg.pool_size);
  end

  // Capture the message and classify it
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item    <= msg;
      n_q     <= n_cfg;
      is_dis  <= (msg.kind == DIS) && msg.to_broadcast;
      is_req  <= (msg.kind == REQ) && !msg.to_broadcast && (msg.receiver_id == cfg.server_id);
      is_rel  <= (msg.kind == REQ) && !msg.to_broadcast && (msg.receiver_id != cfg.server_id);
      addr_ok <= (msg.asked_address != '0) && (17'(msg.asked_address) <= 17'(n_cfg));
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Scan read side: one entry issued per cycle
  assign re    = cmd.scan && (rd_idx < n_q);
  assign raddr = rd_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.load) rd_idx <= '0;
      else if (re) rd_idx <= rd_idx + 1'b1;
      rd_vld <= re;
    end
    wb_addr <= raddr;
  end

  // Expire and release the entry coming back from memory
  always_comb begin
    ent_exp = rdata;
    if (((rdata.status == ST_OFFERED) || (rdata.status == ST_ASSIGNED)) &&
        (rdata.lease_end <= END_W'(item.arrival_time))) begin
      if (rdata.status == ST_OFFERED) begin
        ent_exp.status = ST_FREE;
        ent_exp.owner  = '0;
      end else begin
        ent_exp.status = ST_EXPIRED;
      end
      ent_exp.lease_end = '0;
    end
    ent_wb = ent_exp;
    if (is_rel && (ent_exp.status == ST_OFFERED) && (ent_exp.owner == item.sender_id)) begin
      ent_wb = '0;
    end
  end

  // Track the first owned, free and expired entries and the asked entry
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      own_hit  <= 1'b0;
      free_hit <= 1'b0;
      exp_hit  <= 1'b0;
    end else if (rd_vld) begin
      if (!own_hit && (ent_exp.status != ST_FREE) && (ent_exp.owner == item.sender_id)) begin
        own_hit <= 1'b1;
        own_idx <= wb_addr;
      end
      if (!free_hit && (ent_exp.status == ST_FREE)) begin
        free_hit <= 1'b1;
        free_idx <= wb_addr;
      end
      if (!exp_hit && (ent_exp.status == ST_EXPIRED)) begin
        exp_hit <= 1'b1;
        exp_idx <= wb_addr;
      end
      if ((17'(wb_addr) + 17'd1) == 17'(item.asked_address)) begin
        tgt_st    <= ent_exp.status;
        tgt_owner <= ent_exp.owner;
      end
    end
  end

  // Lease sums, registered during the scan
  always_ff @(posedge clk) begin
    lease_dflt <= END_W'(item.arrival_time) + END_W'(cfg.default_lease);
    lease_lo   <= END_W'(item.arrival_time) + END_W'(cfg.min_lease);
    lease_hi   <= END_W'(item.arrival_time) + END_W'(cfg.max_lease);
  end

  // Clamp the asked end between the limits, or use the default lease if none is asked
  always_comb begin
    lease_mid = (END_W'(item.asked_end) < lease_lo) ? lease_lo : END_W'(item.asked_end);
    if (lease_mid > lease_hi) lease_mid = lease_hi;
    lease_val = (item.asked_end == '0) ? lease_dflt : lease_mid;
  end

  // Decide the reply
  assign offer     = is_dis && (own_hit || free_hit || exp_hit);
  assign grant     = is_req && addr_ok && (tgt_st != ST_FREE) && (tgt_owner == item.sender_id);
  assign has_reply = offer || is_req;
  assign sel_idx   = own_hit ? own_idx : (free_hit ? free_idx : exp_idx);
  assign req_addr_m1 = item.asked_address - 1'b1;

  // Memory write mux: clearing, scan write-back, commit
  always_comb begin
    we    = 1'b0;
    waddr = wb_addr;
    wdata = ent_wb;
    if (cmd.clr) begin
      we    = 1'b1;
      waddr = clr_idx;
      wdata = '0;
    end else if (rd_vld) begin
      we = 1'b1;
    end else if (cmd.commit && offer) begin
      we    = 1'b1;
      waddr = sel_idx;
      wdata = '{status: ST_OFFERED, owner: item.sender_id, lease_end: lease_val};
    end else if (cmd.commit && grant) begin
      we    = 1'b1;
      waddr = req_addr_m1[AW-1:0];
      wdata = '{status: ST_ASSIGNED, owner: item.sender_id, lease_end: lease_val};
    end
  end

  // Reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit && has_reply) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (cmd.commit && has_reply) begin
      rsp_data.client_id <= item.sender_id;
      if (is_dis) begin
        rsp_data.reply_type <= OFR;
        rsp_data.address    <= ID_W'(sel_idx) + 1'b1;
        rsp_data.lease_end  <= lease_val;
      end else begin
        rsp_data.reply_type <= grant ? ACK : NAK;
        rsp_data.address    <= item.asked_address;
        rsp_data.lease_end  <= grant ? lease_val : '0;
      end
    end
  end

  assign sts.clr_done  = (clr_idx == AW'(POOL_DEPTH - 1));
  assign sts.scan_done = (rd_idx == n_q) && !rd_vld;
  assign sts.out_free  = !rsp_valid || !rsp_stall;

endmodule

FILE: rtl/address_lease_server.sv
// Address lease server: top level with configuration registers.
// Uses als_pkg, als_ctrl and als_dp.
//
// Messages enter on req_valid/req_stall/req_data; each accepted transaction
// yields zero or one reply on rsp_valid/rsp_stall/rsp_data. Configuration
// registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high.
// Each message scans the pool one entry per cycle through the pool memory's
// single read port, expiring leases and locating candidates, then commits at
// most one write and the reply, if any. The scan covers the pool size clamped
// to POOL_DEPTH. The input reopens the cycle after the commit, so a new
// message is not taken until the previous one has committed.
// After reset the pool memory is cleared one entry per cycle while req_stall
// stays high; configuration writes are taken then.
// The reply register holds a result while rsp_stall is high; the next message
// is accepted meanwhile, and its commit waits until the reply slot is free.
module address_lease_server #(
  parameter int POOL_DEPTH = als_pkg::POOL_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  als_pkg::msg_t   req_data,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output als_pkg::reply_t rsp_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [29:0]     cfg_data
);
  import als_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pool_size     <= POOL_W'(POOL_DEPTH_DEF);
      cfg.default_lease <= '0;
      cfg.max_lease     <= '0;
      cfg.min_lease     <= '0;
      cfg.server_id     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POOL_SIZE:     cfg.pool_size     <= cfg_data[POOL_W-1:0];
        CFG_DEFAULT_LEASE: cfg.default_lease <= cfg_data;
        CFG_MAX_LEASE:     cfg.max_lease     <= cfg_data;
        CFG_MIN_LEASE:     cfg.min_lease     <= cfg_data;
        CFG_SERVER_ID:     cfg.server_id     <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  als_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  als_dp #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg),
    .msg       (req_data),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data)
  );

  // Commands are mutually exclusive
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr, cmd.load, cmd.scan, cmd.commit}))
    else $error("controller issued overlapping commands");

  // An accepted message blocks the input until it is finished
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("input accepted twice in a row");

  // Commit never overwrites a reply that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp_valid || !rsp_stall))
    else $error("commit while reply slot busy");

endmodule
